// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the echo unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fde_pkg.sv =====
// Package: constants, register map and fixed-point helpers for the echo unit.
package fde_pkg;

  localparam int unsigned LINE_DEPTH_DEF = 524288;
  localparam int unsigned LEN_W          = 20;
  localparam int unsigned SAMPLE_W       = 16;
  localparam int unsigned GAIN_W         = 16;
  localparam int unsigned ADDR_W         = 4;
  localparam int unsigned DATA_W         = 32;

  localparam logic [GAIN_W-1:0] Q15_ONE        = 16'd32768;
  localparam logic [GAIN_W-1:0] DRY_WET_RST    = 16'd16384;
  localparam logic [GAIN_W-1:0] FEEDBACK_RST   = 16'd22938;
  localparam logic [LEN_W-1:0]  DELAY_LEN_RST  = 20'd480000;

  // Register indexes (byte address bits [3:2])
  typedef enum logic [1:0] {
    REG_DRY_WET   = 2'd0,
    REG_FEEDBACK  = 2'd1,
    REG_DELAY_LEN = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  // Clamp a Q1.15 gain to one.
  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
    return (g > Q15_ONE) ? Q15_ONE : g;
  endfunction

  // Round a Q1.15 product half up to an integer sample (17 bit signed).
  function automatic logic signed [16:0] q15_round(input logic signed [33:0] p);
    logic signed [33:0] biased;
    biased = p + 34'sd16384;
    return biased[31:15];
  endfunction

  // Saturate an 18 bit signed sum to 16 bits.
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    if (v < -18'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

endpackage

// ===== rtl/core/feedback_delay_echo_unit.sv =====
// Feedback echo with dry/wet mix: sequencer, shared multiplier, delay line.
// The result is registered at the output and held while the output stalls.
// A new item is accepted only in S_IDLE; one shared 17x17 multiplier is used
// three times in sequence and the delay line memory is read then written once.
// Reset: synchronous rst resets sequencer, pointer, fill count and registers;
// entries past the fill count read as zero, so no clearing pass is run.
module feedback_delay_echo_unit #(
  parameter int unsigned LINE_DEPTH = fde_pkg::LINE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // input item stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [15:0]                 s_tdata,   // [15:0] sample_in
  // result item stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [15:0]                 m_tdata,   // [15:0] sample_out
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fde_pkg::ADDR_W-1:0]  paddr,
  input  logic [fde_pkg::DATA_W-1:0]  pwdata,
  output logic [fde_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  `include "assert_macros.svh"

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned CW = ((AW + 1) > fde_pkg::LEN_W) ? (AW + 1) : fde_pkg::LEN_W;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_WET_MUL, S_WET_RND, S_FB_MUL, S_STORE, S_MIX
  } state_t;

  state_t state;

  // configuration registers
  logic [fde_pkg::GAIN_W-1:0] dry_wet;
  logic [fde_pkg::GAIN_W-1:0] feedback_gain;
  logic [fde_pkg::LEN_W-1:0]  delay_length;

  // datapath registers
  logic [AW-1:0]       ptr;
  logic [AW:0]         fill;
  logic signed [15:0]  sample;
  logic signed [15:0]  rd_data;
  logic                line_hit;
  logic signed [16:0]  wet;
  logic signed [33:0]  prod;

  // delay line
  logic signed [15:0]  mem [LINE_DEPTH];

  logic                cfg_wr;
  fde_pkg::reg_idx_t   cfg_idx;
  logic [fde_pkg::GAIN_W-1:0] dw_c;
  logic [fde_pkg::GAIN_W-1:0] fb_c;
  logic [fde_pkg::GAIN_W-1:0] wet_gain;
  logic [CW-1:0]       len_raw;
  logic [CW-1:0]       len_eff;
  logic [CW-1:0]       ptr_inc;
  logic [AW-1:0]       ptr_next;
  logic signed [16:0]  mul_a;
  logic [fde_pkg::GAIN_W-1:0] mul_b;
  logic signed [16:0]  rnd;
  logic signed [15:0]  line_val;
  logic signed [15:0]  stored;
  logic signed [15:0]  mix;
  logic                mem_we;

  // Decode the configuration port
  assign pready  = 1'b1;
  assign cfg_idx = fde_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      fde_pkg::REG_DRY_WET:   prdata = fde_pkg::DATA_W'(dry_wet);
      fde_pkg::REG_FEEDBACK:  prdata = fde_pkg::DATA_W'(feedback_gain);
      fde_pkg::REG_DELAY_LEN: prdata = fde_pkg::DATA_W'(delay_length);
      default:                prdata = '0;
    endcase
  end

  // Clamp gains and the delay length
  assign dw_c     = fde_pkg::clamp_gain(dry_wet);
  assign fb_c     = fde_pkg::clamp_gain(feedback_gain);
  assign wet_gain = fde_pkg::Q15_ONE - dw_c;
  assign len_raw  = CW'(delay_length);

  always_comb begin
    priority if (len_raw == '0) len_eff = CW'(1);
    else if (len_raw > CW'(LINE_DEPTH)) len_eff = CW'(LINE_DEPTH);
    else len_eff = len_raw;
  end

  // Advance the pointer and wrap at the length in use
  assign ptr_inc  = CW'(ptr) + CW'(1);
  assign ptr_next = (ptr_inc >= len_eff) ? '0 : ptr_inc[AW-1:0];

  // Entries beyond the fill count were never written and read as zero
  assign line_val = line_hit ? rd_data : 16'sd0;

  // Select the shared multiplier operands per step; hold the dry product while the mix waits
  always_comb begin
    unique case (state)
      S_WET_MUL: begin
        mul_a = 17'(line_val);
        mul_b = wet_gain;
      end
      S_FB_MUL: begin
        mul_a = wet;
        mul_b = fb_c;
      end
      S_STORE, S_MIX: begin
        mul_a = 17'(sample);
        mul_b = dw_c;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign rnd    = fde_pkg::q15_round(prod);
  assign stored = fde_pkg::sat16(18'(sample) + 18'(rnd));
  assign mix    = fde_pkg::sat16(18'(wet) + 18'(rnd));
  assign mem_we = (state == S_STORE);

  assign s_tready = (state == S_IDLE);

  // Delay line memory: one registered read, one write
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr] <= stored;
    end
    rd_data <= mem[ptr];
  end

  // Sequencer, datapath and configuration registers
  always_ff @(posedge clk) begin
    prod <= 34'(mul_a) * 34'($signed({1'b0, mul_b}));
    if (rst) begin
      state         <= S_IDLE;
      m_tvalid      <= 1'b0;
      ptr           <= '0;
      fill          <= '0;
      line_hit      <= 1'b0;
      dry_wet       <= fde_pkg::DRY_WET_RST;
      feedback_gain <= fde_pkg::FEEDBACK_RST;
      delay_length  <= fde_pkg::DELAY_LEN_RST;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_idx)
          fde_pkg::REG_DRY_WET:   dry_wet       <= pwdata[fde_pkg::GAIN_W-1:0];
          fde_pkg::REG_FEEDBACK:  feedback_gain <= pwdata[fde_pkg::GAIN_W-1:0];
          fde_pkg::REG_DELAY_LEN: delay_length  <= pwdata[fde_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      // drop the result once taken, unless a new one replaces it
      if (m_tvalid && m_tready && (state != S_MIX)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sample <= s_tdata;
            state  <= S_READ;
          end
        end
        S_READ: begin
          line_hit <= ({1'b0, ptr} < fill);
          state    <= S_WET_MUL;
        end
        S_WET_MUL: state <= S_WET_RND;
        S_WET_RND: begin
          wet   <= rnd;
          state <= S_FB_MUL;
        end
        S_FB_MUL: state <= S_STORE;
        S_STORE: begin
          // grow the written prefix of the line
          if ({1'b0, ptr} == fill) begin
            fill <= fill + (AW + 1)'(1);
          end
          state <= S_MIX;
        end
        S_MIX: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tdata  <= mix;
            m_tvalid <= 1'b1;
            ptr      <= ptr_next;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The pointer never runs past the written prefix
  `ASSERT_CLK(a_ptr_in_fill, ({1'b0, ptr} <= fill), "pointer beyond fill count")
  // The fill count stays within the line
  `ASSERT_CLK(a_fill_max, (fill <= (AW + 1)'(LINE_DEPTH)), "fill count beyond line depth")
  // A waiting result is never overwritten
  `ASSERT_NEXT(a_mix_hold, (state == S_MIX && m_tvalid && !m_tready), (state == S_MIX),
               "result overwritten while output stalled")
  // An accepted item starts the line read
  `ASSERT_NEXT(a_accept_read, (s_tvalid && s_tready), (state == S_READ),
               "accepted item did not start a read")

endmodule
